FILE: src/svt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svt_pkg: shared types and constants of the servo target unit
// Channel count, register indexes, reset values and the record that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package svt_pkg;

	localparam int NCH   = 4;
	localparam int LVL_W = 10;
	localparam int PADQ_W = 5;
	localparam int PADR_W = 12;

	localparam logic [LVL_W-1:0] POT_MAX = 10'd1023;
	localparam int PAD_SCALE = 3000;

	// x / 1023 == (x * RECIP_1023) >> RECIP_SHIFT for x < 2**18
	localparam logic [18:0] RECIP_1023 = 19'd262401;
	localparam int RECIP_SHIFT = 28;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP   = 3'd4;

	typedef logic [NCH-1:0][7:0] byte4_t;

	localparam byte4_t          LOW_RST   = 32'h64B43700;
	localparam byte4_t          HIGH_RST  = 32'h2300AFB4;
	localparam byte4_t          START_RST = 32'h645A375A;
	localparam logic [NCH-1:0]  INV_RST   = 4'hA;
	localparam logic [7:0]      RAMP_RST  = 8'd180;

	// one classified tick
	typedef struct packed {
		logic                          remote;
		logic [NCH-1:0][LVL_W-1:0]     level;
		logic [NCH-1:0][7:0]           pot_tgt;
		logic [NCH-1:0][PADQ_W-1:0]    pad_q;   // floor(pad / 3000), two's complement
		logic [NCH-1:0][PADR_W-1:0]    pad_r;   // pad - 3000 * pad_q, 0..2999
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} push_t;

endpackage
`default_nettype wire

FILE: src/svt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svt_front: tick intake and classification
// Saturates pot words, maps them to target angles and splits the signed
// gamepad step into whole degrees and a remainder, over two stages.
// ----------------------------------------------------------------------------
module svt_front import svt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  tick_valid,
	output logic                       tick_stall,
	input  wire logic [NCH-1:0][15:0]  pot,
	input  wire logic [NCH-1:0][15:0]  pad,
	input  wire logic                  remote_on,
	input  wire byte4_t                lo_cfg,
	input  wire byte4_t                hi_cfg,
	input  wire logic [NCH-1:0]        inv_cfg,
	input  wire logic                  q_full,
	output push_t                      push
);

	logic s1_v_q, s2_v_q;
	logic s2_free, s1_move, s1_free, tick_acc;

	logic [NCH-1:0][LVL_W-1:0]  lvl_c, lvl_s1;
	logic [NCH-1:0][17:0]       prod_c, prod_s1;
	logic [NCH-1:0]             neg_c, neg_s1;
	logic [NCH-1:0][PADQ_W-1:0] padq_c, padq_s1;
	logic [NCH-1:0][PADR_W-1:0] padr_c, padr_s1;
	logic                       remote_s1;
	logic [NCH-1:0][7:0]        tgt_c;
	item_t                      item_s2;

	assign s2_free    = !s2_v_q || !q_full;
	assign s1_move    = s1_v_q && s2_free;
	assign s1_free    = !s1_v_q || s1_move;
	assign tick_stall = !s1_free;
	assign tick_acc   = tick_valid && s1_free;

	// stage 1: saturate, span product, pad split
	always_comb begin : s1_math
		logic [7:0]                ad;
		logic signed [16:0]        p;
		logic [PADQ_W-1:0]         cnt;
		logic signed [PADQ_W-1:0]  q;
		logic signed [17:0]        rem;
		for (int i = 0; i < NCH; i++) begin
			lvl_c[i]  = (pot[i] > 16'(POT_MAX)) ? POT_MAX : pot[i][LVL_W-1:0];
			neg_c[i]  = hi_cfg[i] < lo_cfg[i];
			ad        = neg_c[i] ? (lo_cfg[i] - hi_cfg[i]) : (hi_cfg[i] - lo_cfg[i]);
			prod_c[i] = 18'(lvl_c[i]) * 18'(ad);
			p = inv_cfg[i] ? -17'($signed(pad[i])) : 17'($signed(pad[i]));
			cnt = '0;
			for (int k = -10; k <= 10; k++) begin
				if (int'(p) >= k * PAD_SCALE)
					cnt = cnt + 5'd1;
			end
			q   = $signed(cnt - 5'd11);
			rem = 18'(p) - 18'(int'(q) * PAD_SCALE);
			padq_c[i] = q;
			padr_c[i] = rem[PADR_W-1:0];
		end
	end

	// stage 2: divide by 1023 toward zero and offset from the low angle
	always_comb begin : s2_math
		logic [36:0] scaled;
		logic [7:0]  quo;
		for (int i = 0; i < NCH; i++) begin
			scaled   = 37'(prod_s1[i]) * 37'(RECIP_1023);
			quo      = scaled[RECIP_SHIFT +: 8];
			tgt_c[i] = neg_s1[i] ? (lo_cfg[i] - quo) : (lo_cfg[i] + quo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (s1_free)
				s1_v_q <= tick_valid;
			if (s2_free)
				s2_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			lvl_s1    <= lvl_c;
			prod_s1   <= prod_c;
			neg_s1    <= neg_c;
			padq_s1   <= padq_c;
			padr_s1   <= padr_c;
			remote_s1 <= remote_on;
		end
		if (s1_move) begin
			item_s2.remote  <= remote_s1;
			item_s2.level   <= lvl_s1;
			item_s2.pot_tgt <= tgt_c;
			item_s2.pad_q   <= padq_s1;
			item_s2.pad_r   <= padr_s1;
		end
	end

	assign push.valid = s2_v_q;
	assign push.item  = item_s2;

endmodule
`default_nettype wire

FILE: src/svt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svt_queue: classified tick queue
// Small FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module svt_queue import svt_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       full,
	input  wire logic  pop,
	output logic       avail,
	output item_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr, rd;

	assign full  = cnt_q == CNT_W'(DEPTH);
	assign avail = cnt_q != '0;
	assign wr    = push.valid && !full;
	assign rd    = pop && avail;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q] <= push.item;
	end

endmodule
`default_nettype wire

FILE: src/svt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svt_back: servo state update
// Advances the ramp counter, the per-channel integrator (whole degrees plus remainder
// in 1/3000 degree) and the servo angles, one tick per cycle unless the result stalls.
// ----------------------------------------------------------------------------
module svt_back import svt_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            avail,
	input  wire item_t           head,
	output logic                 pop,
	input  wire byte4_t          lo_cfg,
	input  wire byte4_t          hi_cfg,
	input  wire logic [7:0]      ramp_cfg,
	input  wire logic            start_load,
	input  wire byte4_t          start_val,
	output logic                 res_valid,
	input  wire logic            res_stall,
	output byte4_t               res_angle,
	output logic [NCH-1:0][LVL_W-1:0] res_level,
	output logic                 res_ramp
);

	byte4_t                     deg_q, servo_q;
	logic [NCH-1:0][PADR_W-1:0] frac_q;
	logic [7:0]                 cnt_q;
	logic                       flag_q;

	byte4_t                     deg_nx, servo_nx;
	logic [NCH-1:0][PADR_W-1:0] frac_nx;
	logic [7:0]                 cnt_nx;
	logic                       flag_nx;
	logic                       fire;

	assign fire = avail && (!res_valid || !res_stall);
	assign pop  = fire;

	always_comb begin
		cnt_nx  = (cnt_q < ramp_cfg) ? cnt_q + 8'd1 : cnt_q;
		flag_nx = flag_q && !(cnt_nx >= ramp_cfg);
	end

	always_comb begin : chan_math
		logic [PADR_W:0]    rs;
		logic               c;
		logic [PADR_W-1:0]  r1;
		logic signed [10:0] q1, mn_e, mx_e;
		logic [7:0]         mn, mx, tgt;
		for (int i = 0; i < NCH; i++) begin
			mn = (lo_cfg[i] < hi_cfg[i]) ? lo_cfg[i] : hi_cfg[i];
			mx = (lo_cfg[i] < hi_cfg[i]) ? hi_cfg[i] : lo_cfg[i];
			mn_e = $signed({3'b000, mn});
			mx_e = $signed({3'b000, mx});
			rs = {1'b0, frac_q[i]} + {1'b0, head.pad_r[i]};
			c  = rs >= 13'(PAD_SCALE);
			r1 = c ? 12'(rs - 13'(PAD_SCALE)) : rs[PADR_W-1:0];
			q1 = $signed({3'b000, deg_q[i]}) + 11'($signed(head.pad_q[i]))
				+ $signed({10'd0, c});
			if (!head.remote) begin
				tgt        = head.pot_tgt[i];
				frac_nx[i] = '0;
			end else if (q1 < mn_e) begin
				tgt        = mn;
				frac_nx[i] = '0;
			end else if (q1 > mx_e || (q1 == mx_e && r1 != '0)) begin
				tgt        = mx;
				frac_nx[i] = '0;
			end else begin
				tgt        = q1[7:0];
				frac_nx[i] = r1;
			end
			deg_nx[i] = tgt;
			if (!flag_nx)
				servo_nx[i] = tgt;
			else if (servo_q[i] < tgt)
				servo_nx[i] = servo_q[i] + 8'd1;
			else if (servo_q[i] > tgt)
				servo_nx[i] = servo_q[i] - 8'd1;
			else
				servo_nx[i] = servo_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q     <= START_RST;
			servo_q   <= START_RST;
			frac_q    <= '0;
			cnt_q     <= '0;
			flag_q    <= 1'b1;
			res_valid <= 1'b0;
		end else begin
			if (start_load) begin
				deg_q   <= start_val;
				servo_q <= start_val;
				frac_q  <= '0;
			end else if (fire) begin
				deg_q   <= deg_nx;
				servo_q <= servo_nx;
				frac_q  <= frac_nx;
			end
			if (fire) begin
				cnt_q     <= cnt_nx;
				flag_q    <= flag_nx;
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_angle <= servo_nx;
			res_level <= head.level;
			res_ramp  <= flag_nx;
		end
	end

endmodule
`default_nettype wire

FILE: src/servo_target_with_startup_ramp_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// servo_target_with_startup_ramp_unit: four-channel servo target generator
// Maps pots or integrates gamepad axes into target angles and slews the
// servo angles toward them during a startup ramp.
// ----------------------------------------------------------------------------
//
//   channel  handshake               payload
//   -------  ----------------------  ----------------------------------------
//   tick     tick_valid/tick_stall   pot_0..3, pad_0..3, remote_on
//   result   result_valid/stall      angle_0..3, level_0..3, ramp_active
//   config   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One tick per clock sustained while nothing stalls. An accepted tick reaches
// the result port through two front stages (saturate and span product, then
// the divide by 1023), the queue, and the state update that writes the result
// register. The back end's state loop (integrator add and clamp, then the
// servo step) is combinational between its registers, which sets the rate.
// Reset loads the register defaults and the start angles at once; there is no
// clearing pass. A result stall fills the queue before it stalls tick intake.
//
module servo_target_with_startup_ramp_unit import svt_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 tick_valid,
	output logic                      tick_stall,
	input  wire logic [15:0]          pot_0,
	input  wire logic [15:0]          pot_1,
	input  wire logic [15:0]          pot_2,
	input  wire logic [15:0]          pot_3,
	input  wire logic signed [15:0]   pad_0,
	input  wire logic signed [15:0]   pad_1,
	input  wire logic signed [15:0]   pad_2,
	input  wire logic signed [15:0]   pad_3,
	input  wire logic                 remote_on,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic [7:0]                angle_0,
	output logic [7:0]                angle_1,
	output logic [7:0]                angle_2,
	output logic [7:0]                angle_3,
	output logic [LVL_W-1:0]          level_0,
	output logic [LVL_W-1:0]          level_1,
	output logic [LVL_W-1:0]          level_2,
	output logic [LVL_W-1:0]          level_3,
	output logic                      ramp_active,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	// configuration registers
	byte4_t          low_q, high_q;
	logic [NCH-1:0]  inv_q;
	logic [7:0]      ramp_q;
	logic            cfg_we, start_load;

	logic [NCH-1:0][15:0] pot_v, pad_v;
	push_t                push;
	logic                 q_full, q_avail, q_pop;
	item_t                q_head;
	byte4_t               res_angle;
	logic [NCH-1:0][LVL_W-1:0] res_level;

	// writes go straight into the registers, so always take them
	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign start_load = cfg_we && (cfg_index == CFG_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= LOW_RST;
			high_q  <= HIGH_RST;
			inv_q   <= INV_RST;
			ramp_q  <= RAMP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOW:    low_q   <= cfg_data;
				CFG_HIGH:   high_q  <= cfg_data;
				CFG_START:  ;   // preset goes straight into the back end
				CFG_INVERT: inv_q   <= cfg_data[NCH-1:0];
				CFG_RAMP:   ramp_q  <= cfg_data[7:0];
				default:    ;   // drop writes past the last register
			endcase
		end
	end

	assign pot_v = {pot_3, pot_2, pot_1, pot_0};
	assign pad_v = {pad_3, pad_2, pad_1, pad_0};

	// front: intake, saturate, pot mapping, pad split
	svt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.pot        (pot_v),
		.pad        (pad_v),
		.remote_on  (remote_on),
		.lo_cfg     (low_q),
		.hi_cfg     (high_q),
		.inv_cfg    (inv_q),
		.q_full     (q_full),
		.push       (push)
	);

	// hold classified ticks until the back end takes them
	svt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (q_pop),
		.avail  (q_avail),
		.head   (q_head)
	);

	// back: ramp, integrator and servo state, result register
	svt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.avail      (q_avail),
		.head       (q_head),
		.pop        (q_pop),
		.lo_cfg     (low_q),
		.hi_cfg     (high_q),
		.ramp_cfg   (ramp_q),
		.start_load (start_load),
		.start_val  (cfg_data),
		.res_valid  (result_valid),
		.res_stall  (result_stall),
		.res_angle  (res_angle),
		.res_level  (res_level),
		.res_ramp   (ramp_active)
	);

	assign angle_0 = res_angle[0];
	assign angle_1 = res_angle[1];
	assign angle_2 = res_angle[2];
	assign angle_3 = res_angle[3];
	assign level_0 = res_level[0];
	assign level_1 = res_level[1];
	assign level_2 = res_level[2];
	assign level_3 = res_level[3];

endmodule
`default_nettype wire

FILE: src/svt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svt_checker: port-level checks for the servo target unit
// Watches the tick and result channels and the ramp flag over time.
// ----------------------------------------------------------------------------
module svt_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       tick_valid,
	input wire logic       tick_stall,
	input wire logic       result_valid,
	input wire logic       result_stall,
	input wire logic [7:0] angle_0,
	input wire logic [7:0] angle_1,
	input wire logic [7:0] angle_2,
	input wire logic [7:0] angle_3,
	input wire logic [9:0] level_0,
	input wire logic [9:0] level_1,
	input wire logic [9:0] level_2,
	input wire logic [9:0] level_3,
	input wire logic       ramp_active
);

	logic       in_acc, out_acc;
	logic [7:0] pend_q;
	logic       clear_seen_q;

	assign in_acc  = tick_valid && !tick_stall;
	assign out_acc = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			clear_seen_q <= 1'b0;
		end else begin
			pend_q <= pend_q + {7'd0, in_acc} - {7'd0, out_acc};
			if (out_acc && !ramp_active)
				clear_seen_q <= 1'b1;
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(angle_0)
		&& $stable(angle_1) && $stable(angle_2) && $stable(angle_3)
		&& $stable(level_0) && $stable(level_1) && $stable(level_2)
		&& $stable(level_3) && $stable(ramp_active))
		else $error("result changed while stalled");

	// no result without an accepted tick still owed
	a_owed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 8'd0)
		else $error("result with no outstanding tick");

	// once the ramp has ended it never comes back
	a_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && clear_seen_q |-> !ramp_active)
		else $error("ramp flag set again after clearing");

endmodule

bind servo_target_with_startup_ramp_unit svt_checker u_svt_checker (.*);
`default_nettype wire

FILE: tb/sv/servo_target_with_startup_ramp_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_target_with_startup_ramp_unit_tb: self-checking bench for the servo unit
// Drives control ticks through a short directed table and then random phases
// under several register settings and idle patterns. A behavioral copy of
// the ramp, pot mapping and gamepad integrator predicts the results that are
// not hand-written; every result is compared field by field as it leaves.
// ----------------------------------------------------------------------------
module servo_target_with_startup_ramp_unit_tb;
	import svt_pkg::*;

	localparam int STUCK_LIMIT = 4000;   // cycles with no handshake at all
	localparam int LONG_HOLD = 300;      // long result back-pressure stretch
	localparam int TAIL_CYCLES = 12;     // settle time after the last result
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_RAMP + 3'd1;

	typedef struct packed {
		logic                  remote;
		logic [NCH-1:0][15:0]  pad;
		logic [NCH-1:0][15:0]  pot;
	} tick_t;

	typedef struct packed {
		logic                       ramp;
		logic [NCH-1:0][LVL_W-1:0]  level;
		logic [NCH-1:0][7:0]        angle;
	} servo_out_t;

	typedef struct packed {
		tick_t       tick;
		logic        typed;   // want holds a hand-written result
		servo_out_t  want;
	} dir_row_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  idx;
		logic [31:0]           data;
	} cfg_wr_t;

	// ------------------------------------------------------------------
	// Block ports, all known from time zero
	// ------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tick_valid = 1'b0;
	logic tick_stall;
	logic [15:0] pot_0 = '0, pot_1 = '0, pot_2 = '0, pot_3 = '0;
	logic signed [15:0] pad_0 = '0, pad_1 = '0, pad_2 = '0, pad_3 = '0;
	logic remote_on = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [7:0] angle_0, angle_1, angle_2, angle_3;
	logic [LVL_W-1:0] level_0, level_1, level_2, level_3;
	logic ramp_active;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	servo_target_with_startup_ramp_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.pot_0        (pot_0),
		.pot_1        (pot_1),
		.pot_2        (pot_2),
		.pot_3        (pot_3),
		.pad_0        (pad_0),
		.pad_1        (pad_1),
		.pad_2        (pad_2),
		.pad_3        (pad_3),
		.remote_on    (remote_on),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.angle_0      (angle_0),
		.angle_1      (angle_1),
		.angle_2      (angle_2),
		.angle_3      (angle_3),
		.level_0      (level_0),
		.level_1      (level_1),
		.level_2      (level_2),
		.level_3      (level_3),
		.ramp_active  (ramp_active),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the block: register settings and per-channel state
	// ------------------------------------------------------------------
	byte4_t               low_set = LOW_RST;
	byte4_t               high_set = HIGH_RST;
	byte4_t               start_set = START_RST;
	logic [NCH-1:0]       invert_set = INV_RST;
	logic [7:0]           ramp_len = RAMP_RST;
	logic [NCH-1:0][7:0]  servo_now;
	int                   integ[NCH];   // gamepad integrator, 1/3000 degree
	int                   ramp_elapsed = 0;
	logic                 ramping = 1'b1;

	servo_out_t pending_cmds[$];   // servo commands still owed by the block
	dir_row_t   dir_table[$];
	cfg_wr_t    cfg_plan[$];

	// Run bookkeeping
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int stuck_cycles = 0;
	int bad_fields = 0;
	int ticks_sent = 0;
	int pad_ticks = 0;
	int ramp_ticks_seen = 0;
	int results_seen = 0;
	int cfg_writes = 0;
	logic in_remote = 1'b0;

	// Load servo angles and integrators from the start-angle bytes
	function automatic void preset_servos();
		for (int ch = 0; ch < NCH; ch++) begin
			servo_now[ch] = start_set[ch];
			integ[ch] = int'(start_set[ch]) * PAD_SCALE;
		end
	endfunction

	function automatic void take_setting(input cfg_wr_t w);
		case (w.idx)
			CFG_LOW:    low_set = w.data;
			CFG_HIGH:   high_set = w.data;
			CFG_START: begin
				start_set = w.data;
				preset_servos();
			end
			CFG_INVERT: invert_set = w.data[NCH-1:0];
			CFG_RAMP:   ramp_len = w.data[7:0];
			default: ;
		endcase
	endfunction

	// Advance the shadow by one tick and return the command it produces
	function automatic servo_out_t step_servos(input tick_t t);
		servo_out_t r;
		int lo, hi, mn, mx, acc, pad, tgt;
		logic [LVL_W-1:0] vol;
		// count first, then drop the flag for good once the count is reached
		if (ramp_elapsed < ramp_len)
			ramp_elapsed++;
		if (ramp_elapsed >= ramp_len)
			ramping = 1'b0;
		for (int ch = 0; ch < NCH; ch++) begin
			vol = (t.pot[ch] > POT_MAX) ? POT_MAX : t.pot[ch][LVL_W-1:0];
			lo = low_set[ch];
			hi = high_set[ch];
			if (t.remote) begin
				pad = $signed(t.pad[ch]);
				if (invert_set[ch])
					pad = -pad;
				mn = (lo < hi) ? lo : hi;
				mx = (lo < hi) ? hi : lo;
				acc = integ[ch] + pad;
				if (acc < mn * PAD_SCALE)
					acc = mn * PAD_SCALE;
				if (acc > mx * PAD_SCALE)
					acc = mx * PAD_SCALE;
				integ[ch] = acc;
				tgt = acc / PAD_SCALE;
			end else begin
				// signed divide truncates toward zero on a downward span
				tgt = (int'(vol) * (hi - lo)) / int'(POT_MAX) + lo;
				integ[ch] = tgt * PAD_SCALE;
			end
			if (ramping) begin
				if (int'(servo_now[ch]) < tgt)
					servo_now[ch] = servo_now[ch] + 8'd1;
				else if (int'(servo_now[ch]) > tgt)
					servo_now[ch] = servo_now[ch] - 8'd1;
			end else begin
				servo_now[ch] = tgt[7:0];
			end
			r.angle[ch] = servo_now[ch];
			r.level[ch] = vol;
		end
		r.ramp = ramping;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Item construction
	// ------------------------------------------------------------------
	function automatic tick_t mk_tick(input logic [15:0] p0, p1, p2, p3,
			d0, d1, d2, d3, input logic rem);
		tick_t t;
		t.pot = {p3, p2, p1, p0};
		t.pad = {d3, d2, d1, d0};
		t.remote = rem;
		return t;
	endfunction

	function automatic servo_out_t mk_out(input logic [7:0] a0, a1, a2, a3,
			input logic [LVL_W-1:0] l0, l1, l2, l3, input logic rmp);
		servo_out_t r;
		r.angle = {a3, a2, a1, a0};
		r.level = {l3, l2, l1, l0};
		r.ramp = rmp;
		return r;
	endfunction

	function automatic logic [15:0] rand_pot();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'h03FF;
			2: return 16'h0400;
			3: return 16'hFFFF;
			4, 5, 6: return 16'($urandom_range(1023));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_pad();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3, 4, 5: return 16'($urandom_range(16000) - 8000);
			default: return 16'($urandom);
		endcase
	endfunction

	// Keep the mode for runs of ticks so the integrators can travel
	function automatic tick_t rand_tick();
		if ($urandom_range(7) == 0)
			in_remote = !in_remote;
		return mk_tick(rand_pot(), rand_pot(), rand_pot(), rand_pot(),
			rand_pad(), rand_pad(), rand_pad(), rand_pad(), in_remote);
	endfunction

	// ------------------------------------------------------------------
	// Tick sender
	// ------------------------------------------------------------------
	task automatic send_tick(input tick_t t, input logic typed, input servo_out_t want);
		int gap;
		servo_out_t cmd;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		// drop valid only for a real gap, so a back-to-back item keeps it high
		if (gap != 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_valid <= 1'b1;
		pot_0 <= t.pot[0];
		pot_1 <= t.pot[1];
		pot_2 <= t.pot[2];
		pot_3 <= t.pot[3];
		pad_0 <= t.pad[0];
		pad_1 <= t.pad[1];
		pad_2 <= t.pad[2];
		pad_3 <= t.pad[3];
		remote_on <= t.remote;
		// hold the item until the block takes it
		do
			@(posedge clk);
		while (tick_stall);
		cmd = step_servos(t);
		if (typed)
			cmd = want;
		pending_cmds.push_back(cmd);
		ticks_sent++;
		if (t.remote)
			pad_ticks++;
		if (cmd.ramp)
			ramp_ticks_seen++;
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++)
			send_tick(rand_tick(), 1'b0, '0);
	endtask

	// Drop valid and wait for every owed command to come back
	task automatic drain();
		tick_valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
	endtask

	// Write the queued registers back to back; the block is idle here
	task automatic apply_cfg_plan();
		cfg_wr_t w;
		while (cfg_plan.size() != 0) begin
			w = cfg_plan.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.idx;
			cfg_data <= w.data;
			do
				@(posedge clk);
			while (!cfg_ready);
			take_setting(w);
			cfg_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side: check what leaves, then pick next cycle's stall
	// ------------------------------------------------------------------
	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		bad_fields++;
		if (bad_fields <= 10)
			$display("MISMATCH result %0d %s: expected %0d, got %0d",
				results_seen, what, want, got);
	endtask

	task automatic check_result(input servo_out_t got);
		servo_out_t want;
		if (pending_cmds.size() == 0) begin
			note_mismatch("result with nothing outstanding", 0, 0);
			return;
		end
		want = pending_cmds.pop_front();
		for (int ch = 0; ch < NCH; ch++) begin
			if (got.angle[ch] !== want.angle[ch])
				note_mismatch($sformatf("angle_%0d", ch), want.angle[ch], got.angle[ch]);
			if (got.level[ch] !== want.level[ch])
				note_mismatch($sformatf("level_%0d", ch), want.level[ch], got.level[ch]);
		end
		if (got.ramp !== want.ramp)
			note_mismatch("ramp_active", want.ramp, got.ramp);
	endtask

	always @(posedge clk) begin : result_side
		servo_out_t got;
		if (result_valid && !result_stall) begin
			got.angle = {angle_3, angle_2, angle_1, angle_0};
			got.level = {level_3, level_2, level_1, level_0};
			got.ramp = ramp_active;
			check_result(got);
			results_seen++;
		end
		// a long hold-off request overrides the random stall pattern
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: count cycles in which no channel moves anything
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((tick_valid && !tick_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin : watchdog
		wait (stuck_cycles >= STUCK_LIMIT);
		$display("TIMEOUT: no handshake for %0d cycles", STUCK_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [31:0] word;
		preset_servos();

		// Directed table, run under the reset settings while the ramp is on.
		// Reset bytes: low 0/55/180/100, high 180/175/0/35, start 90/55/90/100,
		// channels 1 and 3 inverted. Early rows step each angle by at most one.
		dir_table.push_back('{mk_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1,
			mk_out(8'd89, 8'd55, 8'd91, 8'd100, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1)});
		dir_table.push_back('{mk_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1,
			mk_out(8'd90, 8'd56, 8'd90, 8'd99,
			10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1)});
		dir_table.push_back('{mk_tick(16'h03FF, 16'h03FF, 16'h03FF, 16'h03FF,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1,
			mk_out(8'd91, 8'd57, 8'd89, 8'd98,
			10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1)});
		dir_table.push_back('{mk_tick(16'h0400, 16'h0400, 16'h0400, 16'h0400,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1,
			mk_out(8'd92, 8'd58, 8'd88, 8'd97,
			10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1)});
		// Gamepad mode from targets at the high angles: full-scale pushes hit
		// both clamps, inverted channels move the other way
		dir_table.push_back('{mk_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1), 1'b0, '0});
		dir_table.push_back('{mk_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1), 1'b0, '0});
		dir_table.push_back('{mk_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1), 1'b0, '0});
		// back to pots: integrators reload from the low-angle targets
		dir_table.push_back('{mk_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b0, '0});
		dir_table.push_back('{mk_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1), 1'b0, '0});
		dir_table.push_back('{mk_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1), 1'b0, '0});
		// small steps around a whole degree
		dir_table.push_back('{mk_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0001, 16'hFFFF, 16'h0BB8, 16'hF448, 1'b1), 1'b0, '0});
		dir_table.push_back('{mk_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'hF448, 16'h0BB8, 16'hFFFF, 16'h0001, 1'b1), 1'b0, '0});
		// pot words around the saturation point and odd fractions
		dir_table.push_back('{mk_tick(16'h8000, 16'h7FFF, 16'h03FE, 16'h0001,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b0, '0});
		dir_table.push_back('{mk_tick(16'h0001, 16'h03FE, 16'h7FFF, 16'h8000,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b0, '0});
		dir_table.push_back('{mk_tick(16'h0200, 16'h0155, 16'h02AA, 16'h0100,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b0, '0});
		dir_table.push_back('{mk_tick(16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF,
			16'h5555, 16'hAAAA, 16'h8001, 16'h7FFE, 1'b1), 1'b0, '0});
		dir_table.push_back('{mk_tick(16'h02AB, 16'h0033, 16'h0366, 16'h01CC,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b0, '0});
		dir_table.push_back('{mk_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h1234, 16'hEDCC, 16'h4000, 16'hC000, 1'b1), 1'b0, '0});
		dir_table.push_back('{mk_tick(16'h03FF, 16'h0000, 16'h03FF, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b0, '0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i])
			send_tick(dir_table[i].tick, dir_table[i].typed, dir_table[i].want);
		drain();

		// Stretch the ramp while it runs, preset the angles mid-ramp, invert
		// every pad and poke a register index that does not exist
		cfg_plan.push_back('{CFG_RAMP, 32'd255});
		cfg_plan.push_back('{CFG_INVERT, 32'hF});
		cfg_plan.push_back('{CFG_START, $urandom});
		cfg_plan.push_back('{CFG_SPARE, $urandom});
		apply_cfg_plan();
		run_random(130);
		drain();

		// Cut the ramp below the elapsed count so it ends at once; widest spans.
		// Sender idles most cycles.
		cfg_plan.push_back('{CFG_RAMP, 32'd100});
		cfg_plan.push_back('{CFG_LOW, 32'h0000_0000});
		cfg_plan.push_back('{CFG_HIGH, 32'hFFFF_FFFF});
		idle_pct = 74;
		apply_cfg_plan();
		run_random(110);
		drain();

		// Downward mapping over the full range, zero ramp length, zero start.
		// Receiver stalls most cycles and opens with a long hold-off, so the
		// queue fills and the tick side backs up while the sender keeps offering.
		cfg_plan.push_back('{CFG_LOW, 32'hFFFF_FFFF});
		cfg_plan.push_back('{CFG_HIGH, 32'h0000_0000});
		cfg_plan.push_back('{CFG_INVERT, 32'h0});
		cfg_plan.push_back('{CFG_RAMP, 32'd0});
		cfg_plan.push_back('{CFG_START, 32'h0000_0000});
		cfg_plan.push_back('{CFG_IDX_W'(CFG_SPARE + $urandom_range(2)), $urandom});
		idle_pct = 0;
		stall_pct = 74;
		apply_cfg_plan();
		hold_req = LONG_HOLD;
		run_random(110);
		drain();

		// Random settings everywhere, light idling on both sides; pause the
		// sender halfway until every command is back
		cfg_plan.push_back('{CFG_LOW, $urandom});
		cfg_plan.push_back('{CFG_HIGH, $urandom});
		cfg_plan.push_back('{CFG_START, $urandom});
		cfg_plan.push_back('{CFG_INVERT, 32'($urandom_range(15))});
		cfg_plan.push_back('{CFG_RAMP, 32'($urandom_range(255))});
		idle_pct = 7;
		stall_pct = 7;
		apply_cfg_plan();
		run_random(50);
		drain();
		run_random(50);
		drain();

		// Top start angles; channel 1 gets equal low and high angles
		word = $urandom;
		cfg_plan.push_back('{CFG_START, 32'hFFFF_FFFF});
		cfg_plan.push_back('{CFG_LOW, word});
		cfg_plan.push_back('{CFG_HIGH, word ^ ($urandom & 32'hFFFF_00FF)});
		cfg_plan.push_back('{CFG_INVERT, 32'($urandom_range(15))});
		apply_cfg_plan();
		idle_pct = 0;
		stall_pct = 0;
		run_random(30);
		idle_pct = 74;
		stall_pct = 74;
		run_random(30);
		idle_pct = 0;
		stall_pct = 7;
		run_random(30);
		drain();

		// let anything stray surface before the verdict
		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d ticks (%0d in gamepad mode, %0d with the ramp on), %0d register writes",
			ticks_sent, pad_ticks, ramp_ticks_seen, cfg_writes);
		$display("Checked %0d results, %0d field mismatches, %0d still owed",
			results_seen, bad_fields, pending_cmds.size());
		if (bad_fields == 0 && pending_cmds.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
